/* rtl/tlfq_pkg.sv */
`timescale 1ns / 1ps
package tlfq_pkg;
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] proc_out;
    logic [1:0]  level_out;
    logic        last;
  } res_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_IO     = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [2:0] EV_IDLE     = 3'd0;
  localparam logic [2:0] EV_DISPATCH = 3'd1;
  localparam logic [2:0] EV_EXPIRED  = 3'd2;
  localparam logic [2:0] EV_ADDED    = 3'd3;
  localparam logic [2:0] EV_FULL     = 3'd4;
  localparam logic [2:0] EV_BLOCKED  = 3'd5;
  localparam logic [2:0] EV_FINISHED = 3'd6;
  localparam logic [2:0] EV_NORUN    = 3'd7;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  localparam logic [1:0] REG_Q1   = 2'd0;
  localparam logic [1:0] REG_Q2   = 2'd1;
  localparam logic [1:0] REG_Q3   = 2'd2;
  localparam logic [1:0] REG_WAIT = 2'd3;

  // controller commands
  typedef struct packed {
    logic clear_scan;  // reset scan index and best pick
    logic scan_step;   // look at one slot for pick or free search
    logic io_step;     // count io for one slot
    logic do_add;
    logic do_dispatch;
    logic do_quantum;
    logic do_io;
    logic do_finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic running;
    logic found;
    logic expire;
  } stat_t;
endpackage

/* rtl/three_level_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps
// one request at a time: a slot scan picks the entry or free slot, then an action step;
// ticks go on to a quantum step and an io count pass over all TABLE_SLOTS slots
// a tick that dispatches first emits the dispatch result, then the quantum step follows
// results wait in an output register while the io count pass runs
// synchronous reset empties the table, stops the running entry and restores registers
module three_level_feedback_queue_scheduler #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlfq_pkg::req_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tlfq_pkg::res_t    out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tlfq_pkg::*;
  logic [7:0] q1, q2, q3, wt;
  req_t req;
  cmd_t cmd;
  stat_t stat;
  logic [2:0] res_event;
  logic [15:0] res_proc;
  logic [1:0] res_level;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      q1 <= 8'd1; q2 <= 8'd2; q3 <= 8'd4; wt <= 8'd3;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_Q1: q1 <= pwdata[7:0];
        REG_Q2: q2 <= pwdata[7:0];
        REG_Q3: q3 <= pwdata[7:0];
        default: wt <= pwdata[7:0];
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_Q1: prdata = {24'd0, q1};
      REG_Q2: prdata = {24'd0, q2};
      REG_Q3: prdata = {24'd0, q3};
      default: prdata = {24'd0, wt};
    endcase
  end

  tlfq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .req, .cmd, .stat,
    .res_event, .res_proc, .res_level, .out_valid, .out_ready, .out_data
  );
  tlfq_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk, .rst, .req, .cmd, .q1, .q2, .q3, .wait_ticks(wt), .stat,
    .res_event, .res_proc, .res_level
  );
endmodule

/* rtl/tlfq_datapath.sv */
`timescale 1ns / 1ps
module tlfq_datapath #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  tlfq_pkg::req_t    req,
  input  tlfq_pkg::cmd_t    cmd,
  input  logic [7:0]        q1,
  input  logic [7:0]        q2,
  input  logic [7:0]        q3,
  input  logic [7:0]        wait_ticks,
  output tlfq_pkg::stat_t   stat,
  output logic [2:0]        res_event,
  output logic [15:0]       res_proc,
  output logic [1:0]        res_level
);
  import tlfq_pkg::*;
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  logic [TABLE_SLOTS-1:0] valid;
  logic [15:0] sproc [TABLE_SLOTS];
  logic [1:0]  slevel [TABLE_SLOTS];
  logic [1:0]  sstatus [TABLE_SLOTS];
  logic [7:0]  sio [TABLE_SLOTS];
  logic [31:0] sstamp [TABLE_SLOTS];
  logic [31:0] order_counter;
  logic [IW-1:0] running_slot;
  logic          running_valid;
  logic [7:0]    quantum_count;

  logic [CW-1:0] scan;
  logic          best_ok;
  logic [IW-1:0] best;
  logic [1:0]    best_lvl;
  logic [31:0]   best_key;
  logic          free_ok;
  logic [IW-1:0] free_slot;

  logic [IW-1:0] si;
  logic [31:0]   key;
  logic          cand;
  logic          better;
  logic [7:0]    qc_inc;
  logic [7:0]    qlim;
  logic [1:0]    rlvl;
  logic [7:0]    io_inc;

  assign si = scan[IW-1:0];
  assign key = sstamp[si] - order_counter;
  assign cand = valid[si] && (sstatus[si] == ST_NEW || sstatus[si] == ST_READY);
  assign better = !best_ok || (slevel[si] < best_lvl) ||
                  (slevel[si] == best_lvl && key < best_key);
  assign qc_inc = (quantum_count == 8'hff) ? quantum_count : quantum_count + 8'd1;
  assign rlvl = slevel[running_slot];
  always_comb begin
    case (rlvl)
      2'd0: qlim = q1;
      2'd1: qlim = q2;
      default: qlim = q3;
    endcase
  end
  assign io_inc = (sio[si] == 8'hff) ? sio[si] : sio[si] + 8'd1;

  assign stat.scan_done = (scan == CW'(TABLE_SLOTS - 1));
  assign stat.running = running_valid;
  assign stat.found = cmd.do_add ? free_ok : best_ok;
  assign stat.expire = running_valid && (qc_inc >= qlim);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      order_counter <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      quantum_count <= '0;
      scan <= '0;
      best_ok <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      if (cmd.clear_scan) begin
        scan <= '0;
        best_ok <= 1'b0;
        free_ok <= 1'b0;
      end
      if (cmd.scan_step || cmd.io_step) begin
        if (scan != CW'(TABLE_SLOTS - 1)) scan <= scan + CW'(1);
      end
      if (cmd.scan_step) begin
        if (cand && better) begin
          best_ok <= 1'b1;
          best <= si;
          best_lvl <= slevel[si];
          best_key <= key;
        end
        if (!valid[si] && !free_ok) begin
          free_ok <= 1'b1;
          free_slot <= si;
        end
      end
      if (cmd.io_step && valid[si] && sstatus[si] == ST_WAITING) begin
        if (io_inc >= wait_ticks) begin
          sstatus[si] <= ST_READY;
          sio[si] <= '0;
        end else begin
          sio[si] <= io_inc;
        end
      end
      if (cmd.do_add) begin
        if (free_ok) begin
          valid[free_slot] <= 1'b1;
          sproc[free_slot] <= req.proc_id;
          slevel[free_slot] <= 2'd0;
          sstatus[free_slot] <= ST_NEW;
          sio[free_slot] <= '0;
          sstamp[free_slot] <= order_counter;
          order_counter <= order_counter + 32'd1;
          res_event <= EV_ADDED;
        end else begin
          res_event <= EV_FULL;
        end
        res_proc <= req.proc_id;
        res_level <= 2'd0;
      end
      if (cmd.do_dispatch) begin
        if (best_ok) begin
          sstatus[best] <= ST_RUNNING;
          running_slot <= best;
          running_valid <= 1'b1;
          quantum_count <= '0;
          res_event <= EV_DISPATCH;
          res_proc <= sproc[best];
          res_level <= slevel[best];
        end else begin
          res_event <= EV_IDLE;
          res_proc <= '0;
          res_level <= '0;
        end
      end
      if (cmd.do_quantum) begin
        if (!running_valid) begin
          res_event <= EV_IDLE;
          res_proc <= '0;
          res_level <= '0;
        end else if (qc_inc >= qlim) begin
          if (rlvl < 2'd2) begin
            slevel[running_slot] <= rlvl + 2'd1;
            sstamp[running_slot] <= order_counter;
            order_counter <= order_counter + 32'd1;
          end
          sstatus[running_slot] <= ST_READY;
          running_valid <= 1'b0;
          running_slot <= '0;
          quantum_count <= '0;
          res_event <= EV_EXPIRED;
          res_proc <= sproc[running_slot];
          res_level <= (rlvl < 2'd2) ? rlvl + 2'd1 : rlvl;
        end else begin
          quantum_count <= qc_inc;
          res_event <= EV_IDLE;
          res_proc <= sproc[running_slot];
          res_level <= rlvl;
        end
      end
      if (cmd.do_io || cmd.do_finish) begin
        if (!running_valid) begin
          res_event <= EV_NORUN;
          res_proc <= '0;
          res_level <= '0;
        end else begin
          if (cmd.do_io) begin
            sstatus[running_slot] <= ST_WAITING;
            sio[running_slot] <= '0;
            if (rlvl > 2'd0) begin
              slevel[running_slot] <= rlvl - 2'd1;
              sstamp[running_slot] <= order_counter;
              order_counter <= order_counter + 32'd1;
            end
            res_event <= EV_BLOCKED;
            res_level <= (rlvl > 2'd0) ? rlvl - 2'd1 : rlvl;
          end else begin
            valid[running_slot] <= 1'b0;
            res_event <= EV_FINISHED;
            res_level <= rlvl;
          end
          res_proc <= sproc[running_slot];
          running_valid <= 1'b0;
          running_slot <= '0;
          quantum_count <= '0;
        end
      end
    end
  end
endmodule

/* rtl/tlfq_ctrl.sv */
`timescale 1ns / 1ps
module tlfq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlfq_pkg::req_t  in_data,
  output tlfq_pkg::req_t  req,
  output tlfq_pkg::cmd_t  cmd,
  input  tlfq_pkg::stat_t stat,
  input  logic [2:0]      res_event,
  input  logic [15:0]     res_proc,
  input  logic [1:0]      res_level,
  output logic            out_valid,
  input  logic            out_ready,
  output tlfq_pkg::res_t  out_data
);
  import tlfq_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ACT, S_QUANT, S_HOLD, S_EMIT, S_EMIT2, S_IO, S_WAIT
  } state_t;
  state_t state;
  logic   disp_hit;
  logic   pending;
  logic   emit_now;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    case (state)
      S_EMIT, S_EMIT2: emit_now = !out_valid || out_ready;
      S_HOLD: emit_now = !pending && (!out_valid || out_ready);
      default: emit_now = 1'b0;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.clear_scan = in_valid && in_ready;
      S_SCAN: cmd.scan_step = 1'b1;
      S_ACT: begin
        case (req.op)
          OP_TICK: cmd.do_dispatch = !stat.running;
          OP_ADD: cmd.do_add = 1'b1;
          OP_IO: cmd.do_io = 1'b1;
          default: cmd.do_finish = 1'b1;
        endcase
      end
      S_QUANT: begin
        cmd.do_quantum = 1'b1;
        cmd.clear_scan = 1'b1;
      end
      S_IO: cmd.io_step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      disp_hit <= 1'b0;
      pending <= 1'b0;
    end else begin
      out_valid <= emit_now || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            disp_hit <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: if (stat.scan_done) state <= S_ACT;
        S_ACT: begin
          if (req.op == OP_TICK && !stat.running) begin
            disp_hit <= stat.found;
            state <= stat.found ? S_EMIT : S_QUANT;
          end else if (req.op == OP_TICK) begin
            state <= S_QUANT;
          end else begin
            state <= S_EMIT2;
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            out_data <= '{res_event, res_proc, res_level, !stat.expire};
            state <= S_QUANT;
          end
        end
        S_QUANT: begin
          pending <= disp_hit && !stat.expire;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (pending) begin
            pending <= 1'b0;
            state <= S_IO;
          end else if (emit_now) begin
            out_data <= '{res_event, res_proc, res_level, 1'b1};
            state <= S_IO;
          end
        end
        S_EMIT2: begin
          if (emit_now) begin
            out_data <= '{res_event, res_proc, res_level, 1'b1};
            state <= S_IDLE;
          end
        end
        S_IO: if (stat.scan_done) state <= S_WAIT;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_SCAN) else $error("bad start");
  assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |=> state == S_IDLE) else $error("bad end");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_add, cmd.do_dispatch, cmd.do_quantum, cmd.do_io, cmd.do_finish}))
    else $error("clash");
endmodule
